// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; take it in by include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/iwa_pkg.sv
// Package of the idle worker allocator: field widths, request kinds, states.
// Depends on nothing; used by the interfaces, the top level and the checker.
package iwa_pkg;

  localparam int MAX_WORKERS_DEF = 16;
  localparam int POOL_RESET      = 16;

  localparam int KIND_W   = 2;
  localparam int WORKER_W = 4;
  localparam int HINT_W   = 4;
  localparam int MAXC_W   = 4;
  localparam int TOTAL_W  = 5;
  localparam int CFG_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_MARK_IDLE   = 2'd0,
    KIND_MARK_ACTIVE = 2'd1,
    KIND_FIND_ONE    = 2'd2,
    KIND_FIND_MANY   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_FINISH,
    ST_MARK
  } state_t;

endpackage

// File: sv/iwa_req_if.sv
// Request channel of the idle worker allocator: valid, ready and payload.
// Depends on iwa_pkg for the field widths.
interface iwa_req_if;
  logic                          valid;
  logic                          ready;
  logic [iwa_pkg::KIND_W-1:0]    kind;
  logic [iwa_pkg::WORKER_W-1:0]  worker;
  logic                          caller_valid;
  logic [iwa_pkg::HINT_W-1:0]    start_hint;
  logic [iwa_pkg::MAXC_W-1:0]    claim_limit;

  modport source (output valid, kind, worker, caller_valid, start_hint, claim_limit,
                  input ready);
  modport sink   (input valid, kind, worker, caller_valid, start_hint, claim_limit,
                  output ready);
endinterface

// File: sv/iwa_res_if.sv
// Result channel of the idle worker allocator: valid, ready and payload.
// Depends on iwa_pkg for the field widths.
interface iwa_res_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [iwa_pkg::WORKER_W-1:0]  granted_worker;
  logic                          last;
  logic [iwa_pkg::TOTAL_W-1:0]   idle_total;

  modport source (output valid, found, granted_worker, last, idle_total,
                  input ready);
  modport sink   (input valid, found, granted_worker, last, idle_total,
                  output ready);
endinterface

// File: sv/idle_worker_allocator.sv
// Idle worker allocator: idle flags, idle count and a sequenced circular scan.
// Depends on iwa_pkg, iwa_req_if and iwa_res_if.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  req      | in        | kind, worker, caller_valid, start_hint, claim_limit
//  res      | out       | found, granted_worker, last, idle_total
//  cfg      | in        | cfg_we, cfg_wdata (workers_in_use, no read-back)
//
// A mark request is accepted, then updates its flag and the count in the MARK state.
// A find request is accepted, then the REDUCE state subtracts the pool size n
// from the scan start until it lies in the pool, the SCAN state reads at most n
// flags (one flag per cycle through the shared add/compare unit, unless a held
// grant stalls the scan) until the scan ends, and FINISH issues the final result.
// Reset (rst, synchronous) clears every idle flag, the count and the state,
// and sets the pool size to 16 (or MAX_WORKERS if smaller).
// A full output register holds each grant, the final result or the mark result
// until it drains, and stalls the scan only when a second grant is hit.
module idle_worker_allocator #(
  parameter int MAX_WORKERS = iwa_pkg::MAX_WORKERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [iwa_pkg::CFG_W-1:0]  cfg_wdata,
  iwa_req_if.sink                    req,
  iwa_res_if.source                  res
);

  // Widths: flag index, idle count / pool size, and a common compare width
  // wide enough for the 4-bit worker and the 5-bit register.
  localparam int IW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CW   = $clog2(MAX_WORKERS + 1);
  localparam int CMPW = (CW > iwa_pkg::CFG_W) ? CW : iwa_pkg::CFG_W;
  localparam int POOL_RST = (iwa_pkg::POOL_RESET > MAX_WORKERS) ?
                            MAX_WORKERS : iwa_pkg::POOL_RESET;

  iwa_pkg::state_t state;
  iwa_pkg::state_t state_next;

  // Worker state.
  logic [MAX_WORKERS-1:0] flags;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [CW-1:0]          pool;
  logic [CW-1:0]          pool_wr;

  // Request held for the duration of its work.
  iwa_pkg::kind_t              kind_r;
  logic [iwa_pkg::WORKER_W-1:0] worker_r;
  logic                        skip_en;
  logic [CMPW-1:0]             ptr;
  logic [CW-1:0]               steps;
  logic [iwa_pkg::MAXC_W-1:0]  remaining;

  // Grant waiting for its last mark to be known.
  logic           pend_valid;
  logic [IW-1:0]  pend_idx;
  logic [CW-1:0]  pend_total;

  // Output register.
  logic                         out_valid;
  logic                         out_found;
  logic [iwa_pkg::WORKER_W-1:0] out_worker;
  logic                         out_last;
  logic [iwa_pkg::TOTAL_W-1:0]  out_total;

  // Datapath.
  iwa_pkg::kind_t               req_kind;
  logic [iwa_pkg::WORKER_W-1:0] req_start;
  logic [iwa_pkg::MAXC_W-1:0]   req_limit;
  logic                         accept;
  logic                         out_free;
  logic [IW-1:0]                addr;
  logic                         flag_rd;
  logic                         in_pool;
  logic                         scan_done;
  logic                         hit;
  logic                         ptr_ge_n;
  logic [CMPW-1:0]              addend;
  logic [CMPW-1:0]              sum;
  logic                         mark_set;
  logic                         mark_clr;

  // Sequencer controls.
  logic step_go;
  logic claim;
  logic push_mid;
  logic fin_go;
  logic mark_go;

  assign req_kind = iwa_pkg::kind_t'(req.kind);
  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || res.ready;

  // Find one with no caller starts at the hint; every other find at the caller.
  assign req_start = (req_kind == iwa_pkg::KIND_FIND_ONE && !req.caller_valid) ?
                     req.start_hint : req.worker;

  // Claim budget: one for find one (zero when none is idle), min(count, claim_limit) for find many.
  always_comb begin
    if (req_kind == iwa_pkg::KIND_FIND_ONE) begin
      req_limit = (count != '0) ? iwa_pkg::MAXC_W'(1) : '0;
    end else if (CMPW'(count) < CMPW'(req.claim_limit)) begin
      req_limit = iwa_pkg::MAXC_W'(count);
    end else begin
      req_limit = req.claim_limit;
    end
  end

  // One read/write address into the flags: the marked worker or the scan slot.
  assign addr    = (state == iwa_pkg::ST_MARK) ? IW'(worker_r) : IW'(ptr);
  assign flag_rd = flags[addr];
  assign in_pool = CMPW'(worker_r) < CMPW'(pool);

  assign scan_done = (steps == pool) || (remaining == '0);
  assign hit       = flag_rd && !(skip_en && (ptr == CMPW'(worker_r)));
  assign ptr_ge_n  = ptr >= CMPW'(pool);

  // Shared unit: subtract the pool size while reducing, step by one while scanning.
  assign addend = (state == iwa_pkg::ST_REDUCE) ? (CMPW'(0) - CMPW'(pool)) : CMPW'(1);
  assign sum    = ptr + addend;

  assign mark_set = in_pool && (kind_r == iwa_pkg::KIND_MARK_IDLE) && !flag_rd;
  assign mark_clr = in_pool && (kind_r == iwa_pkg::KIND_MARK_ACTIVE) && flag_rd;

  // Register write: clamp to 1 .. MAX_WORKERS.
  always_comb begin
    if (cfg_wdata == '0) begin
      pool_wr = CW'(1);
    end else if (CMPW'(cfg_wdata) > CMPW'(MAX_WORKERS)) begin
      pool_wr = CW'(MAX_WORKERS);
    end else begin
      pool_wr = CW'(cfg_wdata);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      iwa_pkg::ST_IDLE: begin
        if (req.valid) begin
          if (req_kind == iwa_pkg::KIND_MARK_IDLE || req_kind == iwa_pkg::KIND_MARK_ACTIVE) begin
            state_next = iwa_pkg::ST_MARK;
          end else begin
            state_next = iwa_pkg::ST_REDUCE;
          end
        end
      end
      iwa_pkg::ST_REDUCE: begin
        if (!ptr_ge_n) begin
          state_next = iwa_pkg::ST_SCAN;
        end
      end
      iwa_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = iwa_pkg::ST_FINISH;
        end
      end
      iwa_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = iwa_pkg::ST_IDLE;
        end
      end
      iwa_pkg::ST_MARK: begin
        if (out_free) begin
          state_next = iwa_pkg::ST_IDLE;
        end
      end
      default: state_next = iwa_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req.ready = 1'b0;
    step_go   = 1'b0;
    claim     = 1'b0;
    push_mid  = 1'b0;
    fin_go    = 1'b0;
    mark_go   = 1'b0;
    case (state)
      iwa_pkg::ST_IDLE: begin
        req.ready = 1'b1;
      end
      iwa_pkg::ST_SCAN: begin
        // Hold the scan when a new grant would have to push the held one
        // into a full output register.
        if (!scan_done) begin
          step_go  = !(hit && pend_valid && !out_free);
          claim    = step_go && hit;
          push_mid = claim && pend_valid;
        end
      end
      iwa_pkg::ST_FINISH: begin
        fin_go = out_free;
      end
      iwa_pkg::ST_MARK: begin
        mark_go = out_free;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (claim) begin
      count_next = count - CW'(1);
    end else if (mark_go && mark_set) begin
      count_next = count + CW'(1);
    end else if (mark_go && mark_clr) begin
      count_next = count - CW'(1);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= iwa_pkg::ST_IDLE;
      flags      <= '0;
      count      <= '0;
      pool       <= CW'(POOL_RST);
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        pool <= pool_wr;
      end
      if (claim) begin
        flags[addr] <= 1'b0;
      end else if (mark_go && in_pool) begin
        flags[addr] <= (kind_r == iwa_pkg::KIND_MARK_IDLE);
      end
      if (accept || fin_go) begin
        pend_valid <= 1'b0;
      end else if (claim) begin
        pend_valid <= 1'b1;
      end
      if (push_mid || fin_go || mark_go) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request hold, scan pointer and pending grant.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= req_kind;
      worker_r  <= req.worker;
      skip_en   <= (req_kind == iwa_pkg::KIND_FIND_MANY) || req.caller_valid;
      ptr       <= CMPW'(req_start);
      steps     <= '0;
      remaining <= req_limit;
    end else if (state == iwa_pkg::ST_REDUCE && ptr_ge_n) begin
      ptr <= sum;
    end else if (step_go) begin
      ptr   <= (sum == CMPW'(pool)) ? '0 : sum;
      steps <= steps + CW'(1);
      if (claim) begin
        remaining <= remaining - iwa_pkg::MAXC_W'(1);
      end
    end
    if (claim) begin
      pend_idx   <= addr;
      pend_total <= count_next;
    end
  end

  // Output payload: a held grant mid sequence, the final result (held grant or empty) or the mark result.
  always_ff @(posedge clk) begin
    if (push_mid) begin
      out_found  <= 1'b1;
      out_worker <= iwa_pkg::WORKER_W'(pend_idx);
      out_last   <= 1'b0;
      out_total  <= iwa_pkg::TOTAL_W'(pend_total);
    end else if (fin_go) begin
      out_found  <= pend_valid;
      out_worker <= pend_valid ? iwa_pkg::WORKER_W'(pend_idx) : '0;
      out_last   <= 1'b1;
      out_total  <= pend_valid ? iwa_pkg::TOTAL_W'(pend_total) : iwa_pkg::TOTAL_W'(count);
    end else if (mark_go) begin
      out_found  <= 1'b0;
      out_worker <= '0;
      out_last   <= 1'b1;
      out_total  <= iwa_pkg::TOTAL_W'(count_next);
    end
  end

  assign res.valid          = out_valid;
  assign res.found          = out_found;
  assign res.granted_worker = out_worker;
  assign res.last           = out_last;
  assign res.idle_total     = out_total;

endmodule

// File: sv/iwa_checker.sv
// Port-level checks on the idle worker allocator, bound to the top level.
// Depends on assert_macros.svh and iwa_pkg.
`include "assert_macros.svh"

module iwa_checker #(
  parameter int MAX_WORKERS = iwa_pkg::MAX_WORKERS_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_found,
  input logic [3:0] res_granted_worker,
  input logic       res_last,
  input logic [4:0] res_idle_total
);

  // An empty result names no worker.
  `ASSERT_ALWAYS(a_empty_no_worker, clk, rst, !(res_valid && !res_found) || (res_granted_worker == 4'd0), "empty result names a worker")

  // The idle count never exceeds the pool capacity.
  `ASSERT_ALWAYS(a_total_bound, clk, rst, !res_valid || (32'(res_idle_total) <= MAX_WORKERS), "idle total above capacity")

  // No new request is taken while a grant sequence is still open.
  `ASSERT_ALWAYS(a_no_req_mid_seq, clk, rst, !(res_valid && !res_last) || !req_ready, "request taken mid sequence")

  // A request keeps the block busy for at least the following cycle.
  `ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready, "ready straight after request")

endmodule

bind idle_worker_allocator iwa_checker #(.MAX_WORKERS(MAX_WORKERS)) u_iwa_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_found          (res.found),
  .res_granted_worker (res.granted_worker),
  .res_last           (res.last),
  .res_idle_total     (res.idle_total)
);
